/* rtl/cfkis_pkg.sv */
// Shared types, constants and the case-fold function of the key insertion sorter.
package cfkis_pkg;

  localparam int KEY_BYTES = 16;
  localparam int KEY_W     = 8 * KEY_BYTES;
  localparam int HALF_W    = KEY_W / 2;

  localparam logic [7:0] ASCII_UPPER_A = 8'h41;
  localparam logic [7:0] ASCII_UPPER_Z = 8'h5A;
  localparam logic [7:0] CASE_OFFSET   = 8'd32;

  // Key bytes: byte 0 sits in the top eight bits, head half above tail half.
  typedef logic [KEY_W-1:0] key_t;

  // Input stage contents: canonical key, its folded copy and the end marker.
  typedef struct packed {
    logic vld;
    logic set_end;
    key_t key;
    key_t fold;
  } stg_t;

  // Per-cell load selects, decided by the chain controller.
  typedef struct packed {
    logic ins_new;
    logic take_prev;
    logic take_next;
  } cell_ctl_t;

  // Fold ASCII upper case letters to lower case, byte by byte.
  function automatic key_t fold_key(input key_t k);
    key_t       f;
    logic [7:0] b;
    f = k;
    for (int i = 0; i < KEY_BYTES; i++) begin
      b = k[KEY_W-1-8*i -: 8];
      if (b >= ASCII_UPPER_A && b <= ASCII_UPPER_Z) begin
        f[KEY_W-1-8*i -: 8] = b + CASE_OFFSET;
      end
    end
    return f;
  endfunction

endpackage

/* rtl/cfkis_canon.sv */
// Input stage: clear bytes past the key end and register the key with its folded copy.
module cfkis_canon
  import cfkis_pkg::*;
#(
  parameter int MAX_BYTES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  logic [63:0] key_head,
  input  logic [63:0] key_tail,
  input  logic        set_end,
  output stg_t        stg
);

  key_t                 raw;
  key_t                 canon;
  logic [KEY_BYTES-1:0] zflag;
  logic [KEY_BYTES-1:0] kill;
  stg_t                 stg_r;

  assign raw = {key_head, key_tail};

  // A byte is dropped when any earlier byte ends the key or when it lies at or past MAX_BYTES.
  always_comb begin
    for (int i = 0; i < KEY_BYTES; i++) begin
      zflag[i] = (raw[KEY_W-1-8*i -: 8] == 8'd0) || (i >= MAX_BYTES);
    end
    for (int i = 0; i < KEY_BYTES; i++) begin
      kill[i] = (i >= MAX_BYTES);
      for (int j = 0; j < i; j++) begin
        kill[i] = kill[i] | zflag[j];
      end
    end
    canon = raw;
    for (int i = 0; i < KEY_BYTES; i++) begin
      if (kill[i]) begin
        canon[KEY_W-1-8*i -: 8] = 8'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_r.vld <= 1'b0;
    end else begin
      stg_r.vld <= load;
    end
    if (load) begin
      stg_r.set_end <= set_end;
      stg_r.key     <= canon;
      stg_r.fold    <= fold_key(canon);
    end
  end

  assign stg = stg_r;

endmodule

/* rtl/cfkis_cell.sv */
// One sorter cell: holds a key, compares it with the incoming key, shifts either way.
module cfkis_cell
  import cfkis_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cell_ctl_t ctl,
  input  logic      desc,
  input  key_t      new_key,
  input  key_t      new_fold,
  input  key_t      prev_key,
  input  key_t      next_key,
  input  logic      next_vld,
  output key_t      key,
  output logic      vld,
  output logic      move
);

  key_t key_r;
  logic vld_r;
  key_t own_fold;

  assign own_fold = fold_key(key_r);
  // Move up past the new key when it must rank ahead of this one.
  assign move     = desc ? (own_fold < new_fold) : (own_fold > new_fold);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ctl.take_next) begin
      vld_r <= next_vld;
    end else if (ctl.ins_new || ctl.take_prev) begin
      vld_r <= 1'b1;
    end
    if (ctl.take_next) begin
      key_r <= next_key;
    end else if (ctl.ins_new) begin
      key_r <= new_key;
    end else if (ctl.take_prev) begin
      key_r <= prev_key;
    end
  end

  assign key = key_r;
  assign vld = vld_r;

endmodule

/* rtl/case_folded_key_insertion_sorter_core.sv */
// Top level of the case-folded key insertion sorter: input stage, cell chain, drain control.
// Flow: a key is registered in the input stage and then written into the cell chain; the first
//   sorted beat shows on out_tvalid after the set_end key has left the stage.
// Throughput: one key per cycle while loading; N stored keys drain in N beats paced by
//   out_tready, with in_tready low from the set_end beat to the pop of the last key.
// Reset: synchronous rst_n empties the chain and clears count, drop flag and direction.
module case_folded_key_insertion_sorter_core
  import cfkis_pkg::*;
#(
  parameter int DEPTH     = 32,
  parameter int MAX_BYTES = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  // configuration: sort_descending
  input  logic         cfg_wr_en,
  input  logic         cfg_wr_data,
  // input stream
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // key_head [63:0], key_tail [127:64]
  input  logic         in_tlast,   // set_end
  // result stream
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // sorted_head [63:0], sorted_tail [127:64]
  output logic         out_tlast,  // run_last
  output logic         out_tuser   // overflowed
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef enum logic {
    S_LOAD,
    S_DRAIN
  } state_t;

  state_t          state_r;
  logic [CNT_W-1:0] count_r;
  logic            drop_r;
  logic            desc_r;
  logic            out_vld_r;
  key_t            out_key_r;
  logic            out_last_r;
  logic            out_ovf_r;

  stg_t            stg;
  logic            in_acc;
  logic            full;
  logic            ins_go;
  logic            drop_go;
  logic            pop;

  key_t             cell_key  [DEPTH];
  logic [DEPTH-1:0] cell_vld;
  logic [DEPTH-1:0] cell_move;
  logic [DEPTH-1:0] mv_or_empty;
  logic [DEPTH-1:0] suf;
  cell_ctl_t        ctl       [DEPTH];

  // Hold off new beats while draining and while the set_end key sits in the stage.
  assign in_tready = (state_r == S_LOAD) && !(stg.vld && stg.set_end);
  assign in_acc    = in_tvalid && in_tready;

  cfkis_canon #(
    .MAX_BYTES(MAX_BYTES)
  ) u_canon (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (in_acc),
    .key_head(in_tdata[63:0]),
    .key_tail(in_tdata[127:64]),
    .set_end (in_tlast),
    .stg     (stg)
  );

  // The chain fills from the bottom, so the top cell being valid means full.
  assign full    = cell_vld[DEPTH-1];
  assign ins_go  = (state_r == S_LOAD) && stg.vld && !full;
  assign drop_go = (state_r == S_LOAD) && stg.vld && full;
  assign pop     = (state_r == S_DRAIN) && (!out_vld_r || out_tready);

  // Empty cells count as movable; the key lands below the run of movable cells at the top.
  assign mv_or_empty = cell_move | ~cell_vld;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam logic [DEPTH-1:0] LOW_MASK = DEPTH'((65'(1) << i) - 65'(1));
    key_t prev_key;
    key_t next_key;
    logic next_vld;

    assign suf[i] = &(mv_or_empty | LOW_MASK);

    if (i == 0) begin : g_bot
      assign prev_key          = '0;
      assign ctl[i].ins_new    = ins_go && suf[i];
      assign ctl[i].take_prev  = 1'b0;
    end else begin : g_mid
      assign prev_key          = cell_key[i-1];
      assign ctl[i].ins_new    = ins_go && suf[i] && !suf[i-1];
      assign ctl[i].take_prev  = ins_go && suf[i-1] && cell_vld[i-1];
    end

    if (i == DEPTH - 1) begin : g_top
      assign next_key = '0;
      assign next_vld = 1'b0;
    end else begin : g_low
      assign next_key = cell_key[i+1];
      assign next_vld = cell_vld[i+1];
    end

    // Drain: every cell takes its upper neighbor as the bottom key leaves.
    assign ctl[i].take_next = pop;

    cfkis_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl[i]),
      .desc    (desc_r),
      .new_key (stg.key),
      .new_fold(stg.fold),
      .prev_key(prev_key),
      .next_key(next_key),
      .next_vld(next_vld),
      .key     (cell_key[i]),
      .vld     (cell_vld[i]),
      .move    (cell_move[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_LOAD;
      count_r   <= '0;
      drop_r    <= 1'b0;
      desc_r    <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        desc_r <= cfg_wr_data;
      end
      unique case (state_r)
        S_LOAD: begin
          if (ins_go) begin
            count_r <= count_r + CNT_W'(1);
          end
          if (drop_go) begin
            drop_r <= 1'b1;
          end
          // Advance to the drain once the set_end key has been placed or dropped.
          if (stg.vld && stg.set_end) begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (pop) begin
            count_r <= count_r - CNT_W'(1);
            if (count_r == CNT_W'(1)) begin
              state_r <= S_LOAD;
              drop_r  <= 1'b0;
            end
          end
        end
        default: begin
          state_r <= S_LOAD;
        end
      endcase
      if (pop) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
    if (pop) begin
      out_key_r  <= cell_key[0];
      out_last_r <= (count_r == CNT_W'(1));
      out_ovf_r  <= drop_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {out_key_r[HALF_W-1:0], out_key_r[KEY_W-1:HALF_W]};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_ovf_r;

  // The number of valid flags equals the stored count.
  a_count_matches_cells: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(cell_vld) == int'(count_r))
    else $error("stored count differs from valid cells");

  // Never take a new beat while the chain drains.
  a_no_accept_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DRAIN) |-> !in_tready)
    else $error("input accepted during drain");

  // Popping the last key leaves an empty chain back in loading.
  a_last_pop_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && count_r == CNT_W'(1)) |=> (state_r == S_LOAD && count_r == '0 && !drop_r))
    else $error("chain not empty after last pop");

  // A drain never starts on an empty chain.
  a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DRAIN) |-> (count_r != '0))
    else $error("drain with empty chain");

  // A key popped before the last one never carries run_last.
  a_last_on_final: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && count_r != CNT_W'(1)) |=> !out_tlast)
    else $error("run_last on a middle key");

endmodule
